// File: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check, off while reset is low.
`define HSAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl failed");
// Clocked check that also runs through reset.
`define HSAT_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("lbl failed");
`endif

// File: design/hsat_pkg.sv
// Shared types and constants of the hashed set-associative translation buffer.
package hsat_pkg;
  localparam int SETS_DEF = 16;
  localparam int WAYS_DEF = 8;
  localparam int VA_W = 32;
  localparam int PA_W = 32;
  localparam int PERM_W = 8;
  localparam int PAGE_SHIFT = 12;
  localparam int TAG_W = VA_W - PAGE_SHIFT;
  localparam int ENTRY_W = TAG_W + PA_W + PERM_W;
  localparam int CHUNK_W = 4;
  localparam int MOD_STEPS = TAG_W / CHUNK_W;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_INVAL  = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } back_st_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [VA_W-1:0]   va;
    logic [PA_W-1:0]   base;
    logic [PERM_W-1:0] perms;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  typedef struct packed {
    logic q_full;
    logic q_push;
  } front_ctl_t;
endpackage

// File: design/hsat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsat_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata_r
);
  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end
endmodule

// File: design/hsat_front.sv
// Front end: accepts words and works out their set index.
module hsat_front #(
  parameter int SETS = hsat_pkg::SETS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  hsat_pkg::req_t          in_req,
  input  logic                    q_full,
  output hsat_pkg::front_ctl_t    ctl,
  output hsat_pkg::req_t          push_req,
  output logic [$clog2(SETS)-1:0] push_set
);
  localparam int SET_W = $clog2(SETS);
  localparam int REM_W = SET_W + 1;
  localparam bit POW2 = (SETS == (1 << SET_W));
  localparam int CNT_W = $clog2(hsat_pkg::MOD_STEPS + 1);

  logic                      hold_vld_r, hold_vld_nxt;
  hsat_pkg::req_t            hold_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [hsat_pkg::TAG_W-1:0] page, shifted;
  logic                      accept, push;

  assign accept = start && !hold_vld_r;
  assign busy = hold_vld_r;
  assign page = hold_r.va[hsat_pkg::VA_W-1:hsat_pkg::PAGE_SHIFT];
  assign push = hold_vld_r && (cnt_r == '0) && !q_full;
  assign shifted = page >> {cnt_r - CNT_W'(1), 2'b00};

  always_comb begin
    rem_nxt = rem_r;
    if (cnt_r != '0) begin
      for (int i = hsat_pkg::CHUNK_W - 1; i >= 0; i--) begin
        rem_nxt = {rem_nxt[REM_W-2:0], shifted[i]};
        if (rem_nxt >= REM_W'(SETS)) begin
          rem_nxt = rem_nxt - REM_W'(SETS);
        end
      end
    end
    cnt_nxt = (cnt_r != '0) ? cnt_r - CNT_W'(1) : cnt_r;
    hold_vld_nxt = hold_vld_r && !push;
    if (accept) begin
      hold_vld_nxt = 1'b1;
      rem_nxt = '0;
      cnt_nxt = POW2 ? '0 : CNT_W'(hsat_pkg::MOD_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    if (accept) begin
      hold_r <= in_req;
    end
  end

  assign ctl.q_full = q_full;
  assign ctl.q_push = push;
  assign push_req = hold_r;
  assign push_set = POW2 ? page[SET_W-1:0] : rem_r[SET_W-1:0];
endmodule

// File: design/hsat_queue.sv
// Two-entry queue between front and back end.
module hsat_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          vld,
  output logic [DW-1:0] pop_data
);
  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full = (cnt_r == 2'd2);
  assign vld = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule

// File: design/hsat_back.sv
// Back end: way storage, fill counts, lookup compare and result register.
module hsat_back #(
  parameter int SETS = hsat_pkg::SETS_DEF,
  parameter int WAYS = hsat_pkg::WAYS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_vld,
  input  hsat_pkg::req_t           q_req,
  input  logic [$clog2(SETS)-1:0]  q_set,
  output logic                     q_pop,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic [hsat_pkg::PA_W-1:0]   out_phys_addr,
  output logic [hsat_pkg::PERM_W-1:0] out_perms_out
);
  localparam int SET_W = $clog2(SETS);
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int TW = hsat_pkg::TAG_W;
  localparam int PW = hsat_pkg::PA_W;
  localparam int MW = hsat_pkg::PERM_W;

  hsat_pkg::back_st_t st_r, st_nxt;
  logic [FILL_W-1:0]  fill_r [SETS];
  logic [FILL_W-1:0]  cur_fill, op_fill_r;
  hsat_pkg::req_t     op_r;
  logic [hsat_pkg::ENTRY_W-1:0] rd [WAYS];
  logic [WAYS-1:0]    we;
  logic [hsat_pkg::ENTRY_W-1:0] wdata;
  logic               found;
  logic [hsat_pkg::ENTRY_W-1:0] sel;
  logic               ov_nxt, hit_nxt;
  logic [PW-1:0]      pa_nxt;
  logic [MW-1:0]      pm_nxt;

  assign cur_fill = fill_r[q_set];
  assign wdata = {q_req.va[hsat_pkg::VA_W-1:hsat_pkg::PAGE_SHIFT], q_req.base, q_req.perms};
  assign q_pop = (st_r == hsat_pkg::ST_IDLE) && q_vld;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    hsat_ram #(.W(hsat_pkg::ENTRY_W), .D(SETS)) u_ram (
      .clk(clk), .we(we[w]), .waddr(q_set), .wdata(wdata),
      .raddr(q_set), .rdata_r(rd[w])
    );
  end

  always_comb begin
    we = '0;
    if (q_pop && q_req.func == hsat_pkg::FN_INSERT) begin
      for (int w = 0; w < WAYS; w++) begin
        if (cur_fill < FILL_W'(WAYS)) we[w] = (FILL_W'(w) == cur_fill);
        else we[w] = (w == WAYS - 1);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    sel = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (FILL_W'(w) < op_fill_r
          && rd[w][hsat_pkg::ENTRY_W-1 -: TW] == op_r.va[hsat_pkg::VA_W-1:hsat_pkg::PAGE_SHIFT]) begin
        found = 1'b1;
        sel = rd[w];
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    ov_nxt = 1'b0;
    hit_nxt = 1'b0;
    pa_nxt = '0;
    pm_nxt = '0;
    unique case (st_r)
      hsat_pkg::ST_IDLE: begin
        if (q_vld) st_nxt = hsat_pkg::ST_EVAL;
      end
      hsat_pkg::ST_EVAL: begin
        st_nxt = hsat_pkg::ST_IDLE;
        ov_nxt = 1'b1;
        case (op_r.func)
          hsat_pkg::FN_LOOKUP: begin
            hit_nxt = found;
            if (found) begin
              pa_nxt = sel[MW +: PW]
                       + {{(PW-hsat_pkg::PAGE_SHIFT){1'b0}}, op_r.va[hsat_pkg::PAGE_SHIFT-1:0]};
              pm_nxt = sel[MW-1:0];
            end
          end
          hsat_pkg::FN_INSERT, hsat_pkg::FN_INVAL: hit_nxt = 1'b1;
          default: hit_nxt = 1'b0;
        endcase
      end
      default: st_nxt = hsat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hsat_pkg::ST_IDLE;
      out_valid <= 1'b0;
      for (int s = 0; s < SETS; s++) fill_r[s] <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid <= ov_nxt;
      if (q_pop && q_req.func == hsat_pkg::FN_INVAL) begin
        for (int s = 0; s < SETS; s++) fill_r[s] <= '0;
      end else if (q_pop && q_req.func == hsat_pkg::FN_INSERT && cur_fill < FILL_W'(WAYS)) begin
        fill_r[q_set] <= cur_fill + FILL_W'(1);
      end
    end
    if (q_pop) begin
      op_r <= q_req;
      op_fill_r <= cur_fill;
    end
    out_hit <= hit_nxt;
    out_phys_addr <= pa_nxt;
    out_perms_out <= pm_nxt;
  end
endmodule

// File: design/hashed_set_assoc_tlb.sv
// From accept to strobe a word passes the front end's hold register, the queue, the way read and the result register.
// The back end pops a new word only when idle, so it ends each word's way read then compare before the next.
// Non-power-of-two SETS adds a 5-step set-index reduction in the front end.
// busy is high while the front end holds a word; results cannot be stalled.
// Synchronous active-low reset empties every set and the queue; no clearing pass.
module hashed_set_assoc_tlb #(
  parameter int SETS = hsat_pkg::SETS_DEF,
  parameter int WAYS = hsat_pkg::WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_virt_addr,
  input  logic [31:0] in_phys_base_in,
  input  logic [7:0]  in_perms_in,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_phys_addr,
  output logic [7:0]  out_perms_out
);
  localparam int SET_W = $clog2(SETS);
  localparam int QW = hsat_pkg::REQ_W + SET_W;

  hsat_pkg::req_t       in_req, push_req, q_req;
  hsat_pkg::front_ctl_t fctl;
  logic [SET_W-1:0]     push_set, q_set;
  logic                 q_full, q_vld, q_pop;

  assign in_req.func = in_func;
  assign in_req.va = in_virt_addr;
  assign in_req.base = in_phys_base_in;
  assign in_req.perms = in_perms_in;

  hsat_front #(.SETS(SETS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .q_full(q_full), .ctl(fctl), .push_req(push_req), .push_set(push_set)
  );

  hsat_queue #(.DW(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(fctl.q_push), .push_data({push_req, push_set}),
    .full(q_full), .pop(q_pop), .vld(q_vld), .pop_data({q_req, q_set})
  );

  hsat_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_vld(q_vld), .q_req(q_req), .q_set(q_set),
    .q_pop(q_pop), .out_valid(out_valid), .out_hit(out_hit),
    .out_phys_addr(out_phys_addr), .out_perms_out(out_perms_out)
  );
endmodule

// File: design/hsat_checker.sv
// Port-level checks for the translation buffer, bound to the top level.
`include "assert_macros.svh"
module hsat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_hit,
  input logic [31:0] out_phys_addr,
  input logic [7:0]  out_perms_out
);
  `HSAT_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_phys_addr == 0 && out_perms_out == 0)
  `HSAT_ASSERT(a_spacing, out_valid |=> !out_valid)
  `HSAT_ASSERT_ANY(a_reset, !rst_n |=> !out_valid && !busy)
endmodule

bind hashed_set_assoc_tlb hsat_checker u_chk (.*);
